>>> rtl/core/entity_slot_allocator_defines.svh
// assertion macros for the entity slot allocator
// used by the top level only
`ifndef ENTITY_SLOT_ALLOCATOR_DEFINES_SVH
`define ENTITY_SLOT_ALLOCATOR_DEFINES_SVH
`define ESA_ASSERT_IMP(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("esa check failed");
`define ESA_ASSERT_NXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("esa check failed");
`endif

>>> rtl/core/esa_pkg.sv
// types and request codes for the entity slot allocator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package esa_pkg;
  localparam logic [3:0] REQ_CREATE   = 4'd0;
  localparam logic [3:0] REQ_DESTROY  = 4'd1;
  localparam logic [3:0] REQ_CLEAR    = 4'd2;
  localparam logic [3:0] REQ_SIZE     = 4'd3;
  localparam logic [3:0] REQ_GET_ID   = 4'd4;
  localparam logic [3:0] REQ_FIND     = 4'd5;
  localparam logic [3:0] REQ_ENABLE   = 4'd6;
  localparam logic [3:0] REQ_DISABLE  = 4'd7;
  localparam logic [3:0] REQ_CHECK    = 4'd8;
  localparam logic [3:0] REQ_TAG      = 4'd9;
  localparam logic [3:0] REQ_UNTAG    = 4'd10;
  localparam logic [3:0] REQ_CHECK_TAG = 4'd11;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_EXEC, S_SCAN, S_SCAN_WAIT, S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic rd;
    logic exec;
    logic scan_rd;
    logic scan_step;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_find;
    logic find_skip;
    logic scan_last;
  } sts_t;
endpackage
`default_nettype wire

>>> rtl/core/esa_ctrl.sv
// controller state machine of the entity slot allocator
// depends on esa_pkg
`timescale 1ns / 1ps
`default_nettype none
module esa_ctrl import esa_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  sts_t      sts,
  output cmd_t      cmd,
  output logic      busy
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (start) state_next = S_READ;
      S_READ: begin
        if (!sts.is_find) state_next = S_EXEC;
        else if (sts.find_skip) state_next = S_DONE;
        else state_next = S_SCAN;
      end
      S_EXEC: state_next = S_IDLE;
      S_SCAN: state_next = S_SCAN_WAIT;
      // the last scan step registers the result beat itself
      S_SCAN_WAIT: state_next = sts.scan_last ? S_IDLE : S_SCAN;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = (state != S_IDLE);
    case (state)
      S_IDLE: cmd.load = start;
      S_READ: cmd.rd = 1'b1;
      S_EXEC: cmd.exec = 1'b1;
      S_SCAN: cmd.scan_rd = 1'b1;
      S_SCAN_WAIT: cmd.scan_step = 1'b1;
      S_DONE: cmd.finish = 1'b1;
      default: cmd = '0;
    endcase
  end
endmodule
`default_nettype wire

>>> rtl/core/esa_dp.sv
// datapath of the entity slot allocator: slot memories, free stack, counters
// depends on esa_pkg
`timescale 1ns / 1ps
`default_nettype none
module esa_dp import esa_pkg::*; #(
  parameter int MAX_SLOTS = 256,
  parameter int ID_BITS = 32,
  parameter int MASK_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  cmd_t             cmd,
  output sts_t             sts,
  input  wire logic [3:0]  req_type,
  input  wire logic [7:0]  slot,
  input  wire logic [31:0] bit_pattern,
  input  wire logic [31:0] entity_id,
  output logic             done,
  output logic [7:0]       slot_out,
  output logic [31:0]      id_out,
  output logic [8:0]       slot_count,
  output logic             test_result,
  output logic [1:0]       status
);
  localparam int AW = $clog2(MAX_SLOTS);
  localparam int CW = AW + 1;
  localparam int SW = (CW > 8) ? CW : 8;
  localparam logic [CW-1:0] MAXC = CW'(MAX_SLOTS);

  logic [ID_BITS-1:0]   ids   [MAX_SLOTS];
  logic [MASK_BITS-1:0] masks [MAX_SLOTS];
  logic [MASK_BITS-1:0] tags  [MAX_SLOTS];
  logic [AW-1:0]        fstack[MAX_SLOTS];
  logic                 onstk [MAX_SLOTS];

  logic [CW-1:0] used, fdepth;
  logic [ID_BITS-1:0] next_id;

  logic [3:0] rq;
  logic [SW-1:0] rs;
  logic [MASK_BITS-1:0] pat;
  logic [ID_BITS-1:0] eid;

  logic [ID_BITS-1:0] r_id;
  logic [MASK_BITS-1:0] r_mask, r_tag;
  logic r_on;
  logic [AW-1:0] r_top;
  logic [CW-1:0] scan;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rq  <= req_type;
      rs  <= SW'(slot);
      pat <= MASK_BITS'({32'd0, bit_pattern} & ((64'd1 << MASK_BITS) - 64'd1));
      eid <= ID_BITS'({32'd0, entity_id});
    end
  end

  logic valid;
  assign valid = (rs < SW'(used)) && (rs < SW'(MAX_SLOTS));
  logic [AW-1:0] sa;
  assign sa = rs[AW-1:0];

  // one registered read of the addressed slot and the stack top
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      r_id   <= ids[sa];
      r_mask <= masks[sa];
      r_tag  <= tags[sa];
      r_on   <= onstk[sa];
      r_top  <= fstack[fdepth[AW-1:0] - AW'(1)];
    end else if (cmd.scan_rd) begin
      r_id <= ids[scan[AW-1:0]];
    end
  end

  assign sts.is_find   = (rq == REQ_FIND);
  assign sts.find_skip = (eid == '0) || (used == '0);
  assign sts.scan_last = (r_id == eid) || (scan + CW'(1) >= used);

  logic [ID_BITS-1:0] id_inc;
  assign id_inc = (next_id + ID_BITS'(1) == '0) ? ID_BITS'(1) : next_id + ID_BITS'(1);

  logic create_pop, create_app;
  assign create_pop = (fdepth != '0);
  assign create_app = !create_pop && (used < MAXC);
  logic [AW-1:0] cidx;
  assign cidx = create_pop ? r_top : used[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      fdepth <= '0;
      next_id <= ID_BITS'(1);
      done <= 1'b0;
      scan <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.load) scan <= '0;
      if (cmd.exec) begin
        done <= 1'b1;
        slot_out <= '0;
        id_out <= '0;
        test_result <= 1'b0;
        status <= ST_OK;
        case (rq)
          REQ_CREATE: begin
            if (create_pop || create_app) begin
              if (create_pop) fdepth <= fdepth - CW'(1);
              else used <= used + CW'(1);
              onstk[cidx] <= 1'b0;
              ids[cidx]   <= next_id;
              masks[cidx] <= '0;
              tags[cidx]  <= '0;
              next_id <= id_inc;
              slot_out <= 8'(cidx);
              id_out <= 32'(next_id);
            end else status <= ST_FULL;
          end
          REQ_DESTROY: begin
            if (!valid) status <= ST_INVALID;
            else begin
              ids[sa] <= '0;
              masks[sa] <= '0;
              tags[sa] <= '0;
              if (!r_on && fdepth < MAXC) begin
                fstack[fdepth[AW-1:0]] <= sa;
                fdepth <= fdepth + CW'(1);
                onstk[sa] <= 1'b1;
              end
            end
          end
          REQ_CLEAR: begin
            used <= '0;
            fdepth <= '0;
          end
          REQ_GET_ID: begin
            if (!valid) status <= ST_INVALID;
            else id_out <= 32'(r_id);
          end
          REQ_ENABLE: begin
            if (!valid) status <= ST_INVALID;
            else masks[sa] <= r_mask | pat;
          end
          REQ_DISABLE: begin
            if (!valid) status <= ST_INVALID;
            else masks[sa] <= r_mask & ~pat;
          end
          REQ_CHECK: begin
            if (!valid) status <= ST_INVALID;
            else test_result <= ((r_mask & pat) == pat);
          end
          REQ_TAG: begin
            if (!valid || r_id == '0) status <= ST_INVALID;
            else tags[sa] <= r_tag | pat;
          end
          REQ_UNTAG: begin
            if (!valid) status <= ST_INVALID;
            else tags[sa] <= r_tag & ~pat;
          end
          REQ_CHECK_TAG: begin
            if (!valid) status <= ST_INVALID;
            else test_result <= ((r_tag & pat) == pat);
          end
          default: status <= ST_OK;
        endcase
      end
      if (cmd.scan_step) begin
        if (r_id == eid) begin
          done <= 1'b1;
          slot_out <= 8'(scan);
          id_out <= 32'(eid);
          test_result <= 1'b0;
          status <= ST_OK;
        end else if (scan + CW'(1) >= used) begin
          done <= 1'b1;
          slot_out <= '0;
          id_out <= '0;
          test_result <= 1'b0;
          status <= ST_INVALID;
        end
        scan <= scan + CW'(1);
      end
      if (cmd.finish) begin
        done <= 1'b1;
        slot_out <= '0;
        id_out <= '0;
        test_result <= 1'b0;
        status <= ST_INVALID;
      end
    end
  end

  assign slot_count = 9'(used);
endmodule
`default_nettype wire

>>> rtl/core/entity_slot_allocator.sv
// top level of the entity slot allocator
// depends on esa_pkg, esa_ctrl, esa_dp and entity_slot_allocator_defines.svh
//
// channel   ports                                   handshake
// request   req_type slot bit_pattern entity_id     start && !busy
// result    slot_out id_out slot_count test_result  done, one cycle
//           status
//
// most requests go through capture, one registered memory read, then the
// read-modify-write that also registers the result beat.
// find index reads and compares id memory slot by slot, up to used_slots slots.
// reset clears the counters only; slot memories need no clearing.
// results cannot be stalled; busy stays high until the result beat.
`timescale 1ns / 1ps
`default_nettype none
`include "entity_slot_allocator_defines.svh"
module entity_slot_allocator import esa_pkg::*; #(
  parameter int MAX_SLOTS = 256,
  parameter int ID_BITS = 32,
  parameter int MASK_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [3:0]  req_type,
  input  wire logic [7:0]  slot,
  input  wire logic [31:0] bit_pattern,
  input  wire logic [31:0] entity_id,
  output logic             done,
  output logic [7:0]       slot_out,
  output logic [31:0]      id_out,
  output logic [8:0]       slot_count,
  output logic             test_result,
  output logic [1:0]       status
);
  cmd_t cmd;
  sts_t sts;

  esa_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .sts(sts), .cmd(cmd), .busy(busy)
  );

  esa_dp #(.MAX_SLOTS(MAX_SLOTS), .ID_BITS(ID_BITS), .MASK_BITS(MASK_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .req_type(req_type), .slot(slot), .bit_pattern(bit_pattern),
    .entity_id(entity_id), .done(done), .slot_out(slot_out), .id_out(id_out),
    .slot_count(slot_count), .test_result(test_result), .status(status)
  );

  `ESA_ASSERT_NXT(a_busy_after_start, start && !busy, busy)
  `ESA_ASSERT_IMP(a_done_busy_free, done, !busy)
  `ESA_ASSERT_IMP(a_status_code, done, status != 2'd3)
endmodule
`default_nettype wire

>>> verif/entity_slot_allocator_test.sv
// testbench for the entity slot allocator: a queued request driver, a result monitor and
// a behavioral model of the slot table that predicts every result beat
// depends on esa_pkg and entity_slot_allocator
`timescale 1ns / 1ps
module entity_slot_allocator_test;
  import esa_pkg::*;

  typedef struct {
    logic [3:0]  req;
    logic [7:0]  slot;
    logic [31:0] pat;
    logic [31:0] eid;
    bit          quiet;  // no random gap in front of this beat
    bit          drain;  // wait until all results are back before sending
  } req_beat_t;

  typedef struct {
    logic [7:0]  slot;
    logic [31:0] id;
    logic [8:0]  count;
    logic        test;
    logic [1:0]  status;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [3:0]  req_type = '0;
  logic [7:0]  slot = '0;
  logic [31:0] bit_pattern = '0;
  logic [31:0] entity_id = '0;
  logic        busy, done, test_result;
  logic [7:0]  slot_out;
  logic [31:0] id_out;
  logic [8:0]  slot_count;
  logic [1:0]  status;

  req_beat_t pending_reqs[$];
  answer_t   expected_answers[$];
  int        mismatches = 0;
  bit        quiet_mode = 1'b0;
  bit        drain_next = 1'b0;

  // model of the slot table
  int unsigned used_cnt = 0;
  int unsigned free_top = 0;
  logic [31:0] ids[256];
  logic [31:0] masks[256];
  logic [31:0] tags[256];
  logic [7:0]  free_slots[256];
  bit          on_free[256];
  logic [31:0] next_id = 32'd1;

  entity_slot_allocator u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .slot(slot), .bit_pattern(bit_pattern), .entity_id(entity_id),
    .done(done), .slot_out(slot_out), .id_out(id_out), .slot_count(slot_count),
    .test_result(test_result), .status(status)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic answer_t apply_request(req_beat_t r);
    answer_t a;
    int unsigned idx;
    bit ok;
    a = '{slot: '0, id: '0, count: '0, test: 1'b0, status: ST_OK};
    ok = r.slot < used_cnt;
    case (r.req)
      REQ_CREATE: begin
        idx = 0;
        if (free_top > 0) begin
          free_top--;
          idx = free_slots[free_top];
        end else if (used_cnt < 256) begin
          idx = used_cnt;
          used_cnt++;
        end else begin
          a.status = ST_FULL;
        end
        if (a.status != ST_FULL) begin
          on_free[idx] = 1'b0;
          ids[idx] = next_id;
          masks[idx] = '0;
          tags[idx] = '0;
          next_id = next_id + 1;
          if (next_id == 0) next_id = 32'd1;
          a.slot = idx[7:0];
          a.id = ids[idx];
        end
      end
      REQ_DESTROY: begin
        if (!ok) a.status = ST_INVALID;
        else begin
          ids[r.slot] = '0;
          masks[r.slot] = '0;
          tags[r.slot] = '0;
          if (!on_free[r.slot]) begin
            free_slots[free_top] = r.slot;
            free_top++;
            on_free[r.slot] = 1'b1;
          end
        end
      end
      REQ_CLEAR: begin
        used_cnt = 0;
        free_top = 0;
      end
      REQ_SIZE: ;
      REQ_GET_ID: begin
        if (!ok) a.status = ST_INVALID;
        else a.id = ids[r.slot];
      end
      REQ_FIND: begin
        a.status = ST_INVALID;
        if (r.eid != 0) begin
          for (int i = 0; i < used_cnt; i++) begin
            if (ids[i] == r.eid) begin
              a.slot = i[7:0];
              a.id = r.eid;
              a.status = ST_OK;
              break;
            end
          end
        end
      end
      REQ_ENABLE: begin
        if (!ok) a.status = ST_INVALID;
        else masks[r.slot] = masks[r.slot] | r.pat;
      end
      REQ_DISABLE: begin
        if (!ok) a.status = ST_INVALID;
        else masks[r.slot] = masks[r.slot] & ~r.pat;
      end
      REQ_CHECK: begin
        if (!ok) a.status = ST_INVALID;
        else a.test = (masks[r.slot] & r.pat) == r.pat;
      end
      REQ_TAG: begin
        if (!ok || ids[r.slot] == 0) a.status = ST_INVALID;
        else tags[r.slot] = tags[r.slot] | r.pat;
      end
      REQ_UNTAG: begin
        if (!ok) a.status = ST_INVALID;
        else tags[r.slot] = tags[r.slot] & ~r.pat;
      end
      REQ_CHECK_TAG: begin
        if (!ok) a.status = ST_INVALID;
        else a.test = (tags[r.slot] & r.pat) == r.pat;
      end
      default: ;
    endcase
    a.count = used_cnt[8:0];
    return a;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // driver: presents queued beats, predicts each one as it is accepted
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_answers = {expected_answers, apply_request(pending_reqs.pop_front())};
      end
      if (start && busy) begin
        // hold the beat until accepted
      end else if (pending_reqs.size() > 0
                   && (!pending_reqs[0].drain || (expected_answers.size() == 0 && !(start && !busy)))
                   && (pending_reqs[0].quiet || $urandom_range(99) >= 33)) begin
        start <= 1'b1;
        req_type <= pending_reqs[0].req;
        slot <= pending_reqs[0].slot;
        bit_pattern <= pending_reqs[0].pat;
        entity_id <= pending_reqs[0].eid;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: every done beat against the oldest prediction
  always @(posedge clk) begin
    answer_t w;
    if (!rst && done) begin
      if (expected_answers.size() == 0) begin
        $display("mismatch at %0t: result beat with nothing expected", $realtime);
        mismatches++;
      end else begin
        w = expected_answers.pop_front();
        if (slot_out !== w.slot) report_mismatch("slot_out", 32'(slot_out), 32'(w.slot));
        if (id_out !== w.id) report_mismatch("id_out", id_out, w.id);
        if (slot_count !== w.count)
          report_mismatch("slot_count", 32'(slot_count), 32'(w.count));
        if (test_result !== w.test)
          report_mismatch("test_result", 32'(test_result), 32'(w.test));
        if (status !== w.status) report_mismatch("status", 32'(status), 32'(w.status));
      end
    end
  end

  task automatic queue_req(input logic [3:0] req, input logic [7:0] s,
                           input logic [31:0] pat, input logic [31:0] eid);
    req_beat_t b;
    b = '{req: req, slot: s, pat: pat, eid: eid, quiet: quiet_mode, drain: drain_next};
    pending_reqs = {pending_reqs, b};
    drain_next = 1'b0;
  endtask

  function automatic logic [31:0] pick_pattern();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return 32'd1 << $urandom_range(31);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int sent;
    int kind;
    int n;
    rst = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed
    queue_req(REQ_CREATE, 8'd0, '0, '0);
    queue_req(REQ_CREATE, 8'd0, '0, '0);
    queue_req(REQ_CREATE, 8'd0, '0, '0);
    queue_req(REQ_GET_ID, 8'd0, '0, '0);
    queue_req(REQ_FIND, 8'd0, '0, 32'd2);
    queue_req(REQ_FIND, 8'd0, '0, 32'd0);
    queue_req(REQ_FIND, 8'd0, '0, 32'hffff_ffff);
    queue_req(REQ_ENABLE, 8'd1, 32'ha5a5_0f0f, '0);
    queue_req(REQ_CHECK, 8'd1, 32'h0505_0101, '0);
    queue_req(REQ_CHECK, 8'd2, 32'd0, '0);
    queue_req(REQ_DISABLE, 8'd1, 32'hffff_ffff, '0);
    queue_req(REQ_CHECK, 8'd1, 32'h0000_0001, '0);
    queue_req(REQ_TAG, 8'd2, 32'hffff_ffff, '0);
    queue_req(REQ_UNTAG, 8'd2, 32'h8000_0000, '0);
    queue_req(REQ_CHECK_TAG, 8'd2, 32'h7fff_ffff, '0);
    queue_req(REQ_DESTROY, 8'd1, '0, '0);
    queue_req(REQ_DESTROY, 8'd1, '0, '0);     // repeated destroy: pushed once
    queue_req(REQ_TAG, 8'd1, 32'd1, '0);      // tag of destroyed slot
    queue_req(REQ_UNTAG, 8'd1, 32'd1, '0);
    queue_req(REQ_GET_ID, 8'd255, '0, '0);    // invalid slot
    queue_req(REQ_DESTROY, 8'd200, '0, '0);
    queue_req(4'd15, 8'hff, '1, '1);          // unused code
    drain_next = 1'b1;
    queue_req(REQ_CREATE, 8'd0, '0, '0);      // reuses freed slot
    queue_req(REQ_CLEAR, 8'd0, '0, '0);
    queue_req(REQ_SIZE, 8'd0, '0, '0);

    // random segments
    sent = 0;
    while (sent < 480) begin
      kind = $urandom_range(9);
      drain_next = ($urandom_range(3) == 0);
      if (kind == 0 && sent < 200) begin
        // fill to capacity and beyond, no gaps
        quiet_mode = 1'b1;
        queue_req(REQ_CLEAR, 8'($urandom), $urandom, $urandom);
        for (int i = 0; i < 258; i++) queue_req(REQ_CREATE, 8'($urandom), $urandom, $urandom);
        queue_req(REQ_FIND, 8'd0, '0, $urandom_range(1, 800));
        queue_req(REQ_DESTROY, 8'($urandom), '0, '0);
        queue_req(REQ_CREATE, 8'd0, '0, '0);
        queue_req(REQ_CREATE, 8'd0, '0, '0);
        quiet_mode = 1'b0;
        sent += 263;
      end else if (kind < 8) begin
        // small table with random work on it
        if ($urandom_range(2) == 0) queue_req(REQ_CLEAR, 8'($urandom), $urandom, $urandom);
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) queue_req(REQ_CREATE, 8'($urandom), $urandom, $urandom);
        for (int i = 0; i < 12; i++) begin
          queue_req(4'($urandom_range(1, 11)),
                    8'(($urandom_range(9) == 0) ? $urandom : $urandom_range(7)),
                    pick_pattern(), ($urandom_range(7) == 0) ? $urandom : $urandom_range(0, 800));
        end
        sent += n + 13;
      end else begin
        // noise
        for (int i = 0; i < 8; i++) queue_req(4'($urandom), 8'($urandom), $urandom, $urandom);
        sent += 8;
      end
    end

    wait (pending_reqs.size() == 0 && !start);
    wait (expected_answers.size() == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_answers.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("Some tests failed");
    $finish;
  end
endmodule
